[design/bfx_pkg.sv]
// Package for the extended tape-language interpreter.
// Holds opcodes, mode and status codes, the greeting table and the decode helpers.
// No dependencies.
`default_nettype none
package bfx_pkg;

  localparam int DEF_CELLS       = 20;
  localparam int DEF_PROG_DEPTH  = 256;
  localparam int DEF_INPUT_DEPTH = 64;
  localparam int GREET_LEN       = 13;
  localparam int SFX_LEN         = 4;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PROG  = 2'd1,
    MODE_INPUT = 2'd2,
    MODE_EXEC  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_RIGHT = 4'd1,
    OP_LEFT  = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_OUT   = 4'd5,
    OP_IN    = 4'd6,
    OP_OPEN  = 4'd7,
    OP_CLOSE = 4'd8,
    OP_OR    = 4'd9,
    OP_AND   = 4'd10,
    OP_XOR   = 4'd11,
    OP_NOT   = 4'd12
  } op_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_RUN      = 3'd0;
  localparam status_t ST_END      = 3'd1;
  localparam status_t ST_RANGE    = 3'd2;
  localparam status_t ST_BRACKET  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  // Program character to opcode
  function automatic op_t decode_char(input logic [7:0] c);
    op_t op;
    case (c)
      8'h3E:   op = OP_RIGHT;  // >
      8'h3C:   op = OP_LEFT;   // <
      8'h2B:   op = OP_INC;    // +
      8'h2D:   op = OP_DEC;    // -
      8'h2E:   op = OP_OUT;    // .
      8'h2C:   op = OP_IN;     // ,
      8'h5B:   op = OP_OPEN;   // [
      8'h5D:   op = OP_CLOSE;  // ]
      8'h7C:   op = OP_OR;     // |
      8'h26:   op = OP_AND;    // &
      8'h5E:   op = OP_XOR;    // ^
      8'h7E:   op = OP_NOT;    // ~
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Appended program [.>]
  function automatic op_t sfx_op(input logic [1:0] i);
    op_t op;
    case (i)
      2'd0:    op = OP_OPEN;
      2'd1:    op = OP_OUT;
      2'd2:    op = OP_RIGHT;
      default: op = OP_CLOSE;
    endcase
    return op;
  endfunction

  // "Hello, world!"
  function automatic logic [7:0] greet_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'd72;
      4'd1:    b = 8'd101;
      4'd2:    b = 8'd108;
      4'd3:    b = 8'd108;
      4'd4:    b = 8'd111;
      4'd5:    b = 8'd44;
      4'd6:    b = 8'd32;
      4'd7:    b = 8'd119;
      4'd8:    b = 8'd111;
      4'd9:    b = 8'd114;
      4'd10:   b = 8'd108;
      4'd11:   b = 8'd100;
      4'd12:   b = 8'd33;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[design/bfx_in_if.sv]
// Input channel of the interpreter: valid/ready plus one item.
// Depends on bfx_pkg.
`default_nettype none
interface bfx_in_if;
  logic            valid;
  logic            ready;
  bfx_pkg::mode_t  mode;
  logic [7:0]      data_byte;
  logic            last_char;

  modport source (output valid, output mode, output data_byte, output last_char,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input last_char,
                  output ready);
endinterface
`default_nettype wire

[design/bfx_out_if.sv]
// Result channel of the interpreter: valid/ready plus one result.
// Depends on bfx_pkg.
`default_nettype none
interface bfx_out_if;
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [7:0]        out_byte;
  bfx_pkg::status_t  status;

  modport source (output valid, output out_valid, output out_byte, output status,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input status,
                  output ready);
endinterface
`default_nettype wire

[design/bfx_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module bfx_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]       rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[design/bf_logic_ext_interpreter.sv]
// Top level of the extended tape-language interpreter: control sequencer and memories.
// Depends on bfx_pkg, bfx_in_if, bfx_out_if, bfx_ram.
//
//   channel  | dir | beat contents                        | handshake
//   in_bus   | in  | mode, data_byte, last_char           | valid/ready
//   out_bus  | out | out_valid, out_byte, status          | valid/ready
//   cfg_*    | in  | extended_mode in cfg_wdata           | cfg_we, no wait
//
// One item at a time. Each command character is stored in the program memory (a ']'
// is first paired with its '[' through the bracket stack); in extended mode the suffix
// commands follow the last one. Logic ops read two cells through the single tape read
// port. Clear and reset both sweep the tape one cell per cycle. A waiting result is held
// in the output register while the next item is taken.
`default_nettype none
module bf_logic_ext_interpreter #(
  parameter int CELLS       = bfx_pkg::DEF_CELLS,
  parameter int PROG_DEPTH  = bfx_pkg::DEF_PROG_DEPTH,
  parameter int INPUT_DEPTH = bfx_pkg::DEF_INPUT_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bfx_in_if.sink    in_bus,
  bfx_out_if.source out_bus,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PLW = PAW + 1;
  localparam int CAW = $clog2(CELLS);
  localparam int QAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int QCW = $clog2(INPUT_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_CLOSE1, S_CLOSE2, S_LNEXT, S_EX1, S_EX2, S_EX3, S_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic              ext_r, ext_nxt;
  logic              loading_r, loading_nxt;
  bfx_pkg::status_t  status_r, status_nxt;
  logic [PLW-1:0]    len_r, len_nxt, pc_r, pc_nxt, top_r, top_nxt;
  logic [15:0]       ptr_r, ptr_nxt;
  logic [QAW-1:0]    qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [QCW-1:0]    qcnt_r, qcnt_nxt;
  logic [CAW-1:0]    clr_idx_r, clr_idx_nxt;
  logic              clr_res_r, clr_res_nxt;
  bfx_pkg::op_t      op_r, op_nxt;
  logic              last_r, last_nxt, in_sfx_r, in_sfx_nxt;
  logic [2:0]        sfx_r, sfx_nxt;
  logic [PAW-1:0]    open_r, open_nxt, jmp_r, jmp_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              res_v_r, res_v_nxt;
  logic [7:0]        res_b_r, res_b_nxt;
  logic              out_full_r, out_full_nxt, out_v_r, out_v_nxt;
  logic [7:0]        out_b_r, out_b_nxt;
  bfx_pkg::status_t  out_s_r, out_s_nxt;

  // Memory ports
  logic           prog_we, prog_re;
  logic [PAW-1:0] prog_waddr;
  logic [3:0]     prog_wdata, prog_rdata;
  logic           jmp_we, jmp_re;
  logic [PAW-1:0] jmp_waddr, jmp_wdata, jmp_rdata;
  logic           brk_we, brk_re;
  logic [PAW-1:0] brk_waddr, brk_raddr, brk_wdata, brk_rdata;
  logic           tape_we, tape_re;
  logic [CAW-1:0] tape_waddr, tape_raddr;
  logic [7:0]     tape_wdata, tape_rdata;
  logic           q_we, q_re;
  logic [7:0]     q_rdata;

  logic           in_fire;
  logic [15:0]    np;
  logic [PLW-1:0] pc_inc, jmp_inc;
  bfx_pkg::op_t   ex_op;
  logic [7:0]     logic_res;

  assign in_bus.ready      = (state_r == S_IDLE);
  assign in_fire           = in_bus.valid && in_bus.ready;
  assign out_bus.valid     = out_full_r;
  assign out_bus.out_valid = out_v_r;
  assign out_bus.out_byte  = out_b_r;
  assign out_bus.status    = out_s_r;

  assign np      = ptr_r + 16'd1;
  assign pc_inc  = pc_r + PLW'(1);
  assign jmp_inc = PLW'(jmp_r) + PLW'(1);
  assign ex_op   = bfx_pkg::op_t'(prog_rdata);

  // Combine for the logic commands: a is the new cell, b the previous one
  always_comb begin
    case (op_r)
      bfx_pkg::OP_OR:  logic_res = tape_rdata | b_r;
      bfx_pkg::OP_AND: logic_res = tape_rdata & b_r;
      default:         logic_res = tape_rdata ^ b_r;
    endcase
  end

  // Sequencer next state and memory control
  always_comb begin
    state_nxt    = state_r;
    ext_nxt      = cfg_we ? cfg_wdata : ext_r;
    loading_nxt  = loading_r;
    status_nxt   = status_r;
    len_nxt      = len_r;
    pc_nxt       = pc_r;
    top_nxt      = top_r;
    ptr_nxt      = ptr_r;
    qhead_nxt    = qhead_r;
    qtail_nxt    = qtail_r;
    qcnt_nxt     = qcnt_r;
    clr_idx_nxt  = clr_idx_r;
    clr_res_nxt  = clr_res_r;
    op_nxt       = op_r;
    last_nxt     = last_r;
    in_sfx_nxt   = in_sfx_r;
    sfx_nxt      = sfx_r;
    open_nxt     = open_r;
    jmp_nxt      = jmp_r;
    b_nxt        = b_r;
    res_v_nxt    = res_v_r;
    res_b_nxt    = res_b_r;
    out_full_nxt = out_full_r && !out_bus.ready;
    out_v_nxt    = out_v_r;
    out_b_nxt    = out_b_r;
    out_s_nxt    = out_s_r;

    prog_we = 1'b0; prog_re = 1'b0; prog_waddr = len_r[PAW-1:0]; prog_wdata = op_r;
    jmp_we = 1'b0; jmp_re = 1'b0; jmp_waddr = len_r[PAW-1:0]; jmp_wdata = open_r;
    brk_we = 1'b0; brk_re = 1'b0; brk_waddr = top_r[PAW-1:0];
    brk_raddr = top_r[PAW-1:0] - PAW'(1); brk_wdata = len_r[PAW-1:0];
    tape_we = 1'b0; tape_re = 1'b0; tape_waddr = ptr_r[CAW-1:0];
    tape_raddr = ptr_r[CAW-1:0]; tape_wdata = 8'd0;
    q_we = 1'b0; q_re = 1'b0;

    case (state_r)
      // Tape sweep: greeting bytes (in extended mode only) then zeros
      S_CLR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_idx_r;
        tape_wdata = (ext_r && clr_idx_r < CAW'(bfx_pkg::GREET_LEN))
                     ? bfx_pkg::greet_byte(clr_idx_r[3:0]) : 8'd0;
        if (clr_idx_r == CAW'(CELLS - 1)) begin
          state_nxt = clr_res_r ? S_RES : S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + CAW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          res_v_nxt = 1'b0;
          res_b_nxt = 8'd0;
          state_nxt = S_RES;
          case (in_bus.mode)
            bfx_pkg::MODE_CLEAR: begin
              state_nxt   = S_CLR;
              clr_idx_nxt = '0;
              clr_res_nxt = 1'b1;
              loading_nxt = 1'b1;
              status_nxt  = bfx_pkg::ST_RUN;
              len_nxt = '0; pc_nxt = '0; top_nxt = '0; ptr_nxt = '0;
              qhead_nxt = '0; qtail_nxt = '0; qcnt_nxt = '0;
            end
            bfx_pkg::MODE_PROG: begin
              if (loading_r) begin
                op_nxt     = bfx_pkg::decode_char(in_bus.data_byte);
                last_nxt   = in_bus.last_char;
                in_sfx_nxt = 1'b0;
                sfx_nxt    = '0;
                state_nxt  = S_LOAD;
              end
            end
            bfx_pkg::MODE_INPUT: begin
              if (qcnt_r < QCW'(INPUT_DEPTH)) begin
                q_we      = 1'b1;
                qtail_nxt = (qtail_r == QAW'(INPUT_DEPTH - 1)) ? '0 : qtail_r + QAW'(1);
                qcnt_nxt  = qcnt_r + QCW'(1);
              end
            end
            default: begin
              if (!loading_r && status_r == bfx_pkg::ST_RUN) begin
                if (pc_r >= len_r) begin
                  status_nxt = bfx_pkg::ST_END;
                end else begin
                  prog_re   = 1'b1;
                  jmp_re    = 1'b1;
                  state_nxt = S_EX1;
                end
              end
            end
          endcase
        end
      end

      // Store one command and keep the bracket pairing
      S_LOAD: begin
        state_nxt = S_LNEXT;
        if (status_r == bfx_pkg::ST_RUN && op_r != bfx_pkg::OP_NONE) begin
          if (len_r == PLW'(PROG_DEPTH)) begin
            status_nxt = bfx_pkg::ST_OVERFLOW;
          end else if (op_r == bfx_pkg::OP_OPEN) begin
            brk_we  = 1'b1;
            prog_we = 1'b1;
            top_nxt = top_r + PLW'(1);
            len_nxt = len_r + PLW'(1);
          end else if (op_r == bfx_pkg::OP_CLOSE) begin
            if (top_r == '0) begin
              status_nxt = bfx_pkg::ST_BRACKET;
            end else begin
              brk_re    = 1'b1;
              top_nxt   = top_r - PLW'(1);
              state_nxt = S_CLOSE1;
            end
          end else begin
            prog_we = 1'b1;
            len_nxt = len_r + PLW'(1);
          end
        end
      end

      // Matching open index arrives; link both directions over two writes
      S_CLOSE1: begin
        open_nxt  = brk_rdata;
        jmp_we    = 1'b1;
        jmp_waddr = brk_rdata;
        jmp_wdata = len_r[PAW-1:0];
        state_nxt = S_CLOSE2;
      end

      S_CLOSE2: begin
        jmp_we    = 1'b1;
        prog_we   = 1'b1;
        len_nxt   = len_r + PLW'(1);
        state_nxt = S_LNEXT;
      end

      // Suffix commands, then end of load
      S_LNEXT: begin
        state_nxt = S_RES;
        if (in_sfx_r && sfx_r != 3'(bfx_pkg::SFX_LEN)) begin
          op_nxt    = bfx_pkg::sfx_op(sfx_r[1:0]);
          sfx_nxt   = sfx_r + 3'd1;
          state_nxt = S_LOAD;
        end else if (last_r && !in_sfx_r && ext_r) begin
          in_sfx_nxt = 1'b1;
          op_nxt     = bfx_pkg::sfx_op(2'd0);
          sfx_nxt    = 3'd1;
          state_nxt  = S_LOAD;
        end else if (last_r) begin
          if (status_r == bfx_pkg::ST_RUN && top_r != '0) begin
            status_nxt = bfx_pkg::ST_BRACKET;
          end
          loading_nxt = 1'b0;
        end
      end

      // Opcode and jump target available
      S_EX1: begin
        jmp_nxt   = jmp_rdata;
        op_nxt    = ex_op;
        state_nxt = S_RES;
        case (ex_op)
          bfx_pkg::OP_RIGHT, bfx_pkg::OP_LEFT: begin
            ptr_nxt = (ex_op == bfx_pkg::OP_RIGHT) ? np : ptr_r - 16'd1;
            pc_nxt  = pc_inc;
            if (pc_inc >= len_r) begin
              status_nxt = bfx_pkg::ST_END;
            end
          end
          bfx_pkg::OP_OR, bfx_pkg::OP_AND, bfx_pkg::OP_XOR: begin
            if (ptr_r >= 16'(CELLS) || np >= 16'(CELLS)) begin
              status_nxt = bfx_pkg::ST_RANGE;
            end else begin
              tape_re   = 1'b1;
              state_nxt = S_EX2;
            end
          end
          default: begin
            if (ptr_r >= 16'(CELLS)) begin
              status_nxt = bfx_pkg::ST_RANGE;
            end else begin
              tape_re   = 1'b1;
              q_re      = 1'b1;
              state_nxt = S_EX2;
            end
          end
        endcase
      end

      // Current cell available
      S_EX2: begin
        state_nxt = S_RES;
        pc_nxt    = pc_inc;
        tape_wdata = tape_rdata;
        case (op_r)
          bfx_pkg::OP_OR, bfx_pkg::OP_AND, bfx_pkg::OP_XOR: begin
            b_nxt      = tape_rdata;
            tape_re    = 1'b1;
            tape_raddr = np[CAW-1:0];
            pc_nxt     = pc_r;
            state_nxt  = S_EX3;
          end
          bfx_pkg::OP_INC: begin
            tape_we = 1'b1; tape_wdata = tape_rdata + 8'd1;
          end
          bfx_pkg::OP_DEC: begin
            tape_we = 1'b1; tape_wdata = tape_rdata - 8'd1;
          end
          bfx_pkg::OP_NOT: begin
            tape_we = 1'b1; tape_wdata = ~tape_rdata;
          end
          bfx_pkg::OP_OUT: begin
            res_v_nxt = 1'b1;
            res_b_nxt = tape_rdata;
          end
          bfx_pkg::OP_IN: begin
            if (qcnt_r != '0) begin
              tape_we    = 1'b1;
              tape_wdata = q_rdata;
              qhead_nxt  = (qhead_r == QAW'(INPUT_DEPTH - 1)) ? '0 : qhead_r + QAW'(1);
              qcnt_nxt   = qcnt_r - QCW'(1);
            end
          end
          bfx_pkg::OP_OPEN: begin
            if (tape_rdata == 8'd0) pc_nxt = jmp_inc;
          end
          bfx_pkg::OP_CLOSE: begin
            if (tape_rdata != 8'd0) pc_nxt = jmp_inc;
          end
          default: begin
          end
        endcase
        if (state_nxt == S_RES && pc_nxt >= len_r) begin
          status_nxt = bfx_pkg::ST_END;
        end
      end

      // Neighbor cell available: combine and write back
      S_EX3: begin
        tape_we    = 1'b1;
        tape_waddr = np[CAW-1:0];
        tape_wdata = logic_res;
        ptr_nxt    = np;
        pc_nxt     = pc_inc;
        if (pc_inc >= len_r) begin
          status_nxt = bfx_pkg::ST_END;
        end
        state_nxt = S_RES;
      end

      // Hand the result to the output register
      S_RES: begin
        if (!out_full_r || out_bus.ready) begin
          out_full_nxt = 1'b1;
          out_v_nxt    = res_v_r;
          out_b_nxt    = res_b_r;
          out_s_nxt    = status_r;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      ext_r      <= 1'b1;
      loading_r  <= 1'b1;
      status_r   <= bfx_pkg::ST_RUN;
      len_r      <= '0;
      pc_r       <= '0;
      top_r      <= '0;
      ptr_r      <= '0;
      qhead_r    <= '0;
      qtail_r    <= '0;
      qcnt_r     <= '0;
      clr_idx_r  <= '0;
      clr_res_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ext_r      <= ext_nxt;
      loading_r  <= loading_nxt;
      status_r   <= status_nxt;
      len_r      <= len_nxt;
      pc_r       <= pc_nxt;
      top_r      <= top_nxt;
      ptr_r      <= ptr_nxt;
      qhead_r    <= qhead_nxt;
      qtail_r    <= qtail_nxt;
      qcnt_r     <= qcnt_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_res_r  <= clr_res_nxt;
      out_full_r <= out_full_nxt;
    end
    op_r     <= op_nxt;
    last_r   <= last_nxt;
    in_sfx_r <= in_sfx_nxt;
    sfx_r    <= sfx_nxt;
    open_r   <= open_nxt;
    jmp_r    <= jmp_nxt;
    b_r      <= b_nxt;
    res_v_r  <= res_v_nxt;
    res_b_r  <= res_b_nxt;
    out_v_r  <= out_v_nxt;
    out_b_r  <= out_b_nxt;
    out_s_r  <= out_s_nxt;
  end

  bfx_ram #(.W(4), .D(PROG_DEPTH)) u_prog (
    .clk, .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
    .re(prog_re), .raddr(pc_r[PAW-1:0]), .rdata(prog_rdata)
  );

  bfx_ram #(.W(PAW), .D(PROG_DEPTH)) u_jump (
    .clk, .we(jmp_we), .waddr(jmp_waddr), .wdata(jmp_wdata),
    .re(jmp_re), .raddr(pc_r[PAW-1:0]), .rdata(jmp_rdata)
  );

  bfx_ram #(.W(PAW), .D(PROG_DEPTH)) u_brk (
    .clk, .we(brk_we), .waddr(brk_waddr), .wdata(brk_wdata),
    .re(brk_re), .raddr(brk_raddr), .rdata(brk_rdata)
  );

  bfx_ram #(.W(8), .D(CELLS)) u_tape (
    .clk, .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .re(tape_re), .raddr(tape_raddr), .rdata(tape_rdata)
  );

  bfx_ram #(.W(8), .D(INPUT_DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(qtail_r), .wdata(in_bus.data_byte),
    .re(q_re), .raddr(qhead_r), .rdata(q_rdata)
  );

  // Checks
  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCW'(INPUT_DEPTH))
    else $error("input queue count beyond depth");

  a_stack: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= len_r)
    else $error("bracket stack deeper than program");

  // An empty program stays running until the first step finds the end
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    !loading_r && status_r == bfx_pkg::ST_RUN && len_r != '0 |-> pc_r < len_r)
    else $error("running with program counter at or past end");

  a_outbyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.out_valid |->
      out_bus.status == bfx_pkg::ST_RUN || out_bus.status == bfx_pkg::ST_END)
    else $error("output beat with fault status");
endmodule
`default_nettype wire
